// ===== hw/rtl/biq_pkg.sv =====
`default_nettype none

package biq_pkg;

	localparam int SAMPLE_W = 32;
	localparam int FRAC_W   = 16;
	localparam int IDX_W    = 3;

	typedef logic signed [SAMPLE_W-1:0] sample_t;

	typedef enum logic [IDX_W-1:0] {
		REG_B0 = 3'd0,
		REG_B1 = 3'd1,
		REG_B2 = 3'd2,
		REG_A1 = 3'd3,
		REG_A2 = 3'd4
	} reg_idx_t;

	// 1.0 in Q16.16
	localparam sample_t COEF_ONE  = sample_t'(32'sh0001_0000);
	localparam sample_t COEF_ZERO = sample_t'(32'sh0000_0000);

endpackage

`default_nettype wire

// ===== hw/rtl/biq_mul.sv =====
`default_nettype none

// Q16.16 multiply in sign-magnitude form: |a|*|b| >> 16, then the sign.
module biq_mul (
	input  biq_pkg::sample_t a,
	input  biq_pkg::sample_t b,
	output biq_pkg::sample_t p
);
	import biq_pkg::*;

	logic [SAMPLE_W-1:0]   a_mag;
	logic [SAMPLE_W-1:0]   b_mag;
	logic [2*SAMPLE_W-1:0] prod;
	logic [SAMPLE_W-1:0]   p_mag;
	logic                  neg;

	// most negative value maps to 2^31, which fits unsigned
	assign a_mag = a[SAMPLE_W-1] ? (~$unsigned(a) + 1'b1) : $unsigned(a);
	assign b_mag = b[SAMPLE_W-1] ? (~$unsigned(b) + 1'b1) : $unsigned(b);
	assign neg   = a[SAMPLE_W-1] ^ b[SAMPLE_W-1];

	assign prod  = (2*SAMPLE_W)'(a_mag) * (2*SAMPLE_W)'(b_mag);
	// truncation toward zero, upper bits beyond 32 dropped
	assign p_mag = prod[FRAC_W +: SAMPLE_W];
	assign p     = neg ? $signed(~p_mag + 1'b1) : $signed(p_mag);

endmodule

`default_nettype wire

// ===== hw/rtl/biquad_q16_filter.sv =====
`default_nettype none

// channel   | dir | beat content
// ----------+-----+-------------------------------------------------
// s_axis    | in  | tdata[31:0] = sample_in (signed Q16.16)
// m_axis    | out | tdata[31:0] = sample_out (signed Q16.16)
// cfg       | in  | cfg_index = register (b0,b1,b2,a1,a2), cfg_data
//
// One sample per cycle sustained while m_axis takes results. A beat is registered
// in x_s1, its result in out_data_q on m_axis. Five 32x32 multiplies and the
// wrapping sum sit between the two, closing the feedback through the histories.
// Reset clears the histories and loads b0 = 1.0, other coefficients zero.
// A stalled m_axis holds the result; the input register still takes one beat.
module biquad_q16_filter (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               s_axis_tvalid,
	output      logic               s_axis_tready,
	input  wire biq_pkg::sample_t   s_axis_tdata,   // [31:0] sample_in
	output      logic               m_axis_tvalid,
	input  wire logic               m_axis_tready,
	output      biq_pkg::sample_t   m_axis_tdata,   // [31:0] sample_out
	input  wire logic               cfg_valid,
	output      logic               cfg_ready,
	input  wire logic [2:0]         cfg_index,
	input  wire biq_pkg::sample_t   cfg_data
);
	import biq_pkg::*;

	sample_t coef_b0_q, coef_b1_q, coef_b2_q, coef_a1_q, coef_a2_q;
	sample_t x_hist_1_q, x_hist_2_q, y_hist_1_q, y_hist_2_q;
	sample_t x_s1;
	logic    v_s1;
	sample_t out_data_q;
	logic    out_valid_q;
	logic    adv_s1;
	logic    in_fire;
	sample_t p_b0, p_b1, p_b2, p_a1, p_a2;
	sample_t y_s1;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			coef_b0_q <= COEF_ONE;
			coef_b1_q <= COEF_ZERO;
			coef_b2_q <= COEF_ZERO;
			coef_a1_q <= COEF_ZERO;
			coef_a2_q <= COEF_ZERO;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				REG_B0:  coef_b0_q <= cfg_data;
				REG_B1:  coef_b1_q <= cfg_data;
				REG_B2:  coef_b2_q <= cfg_data;
				REG_A1:  coef_a1_q <= cfg_data;
				REG_A2:  coef_a2_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// stage 1 moves on when the output register is empty or being drained
	assign adv_s1        = v_s1 && (!out_valid_q || m_axis_tready);
	assign s_axis_tready = !v_s1 || adv_s1;
	assign in_fire       = s_axis_tvalid && s_axis_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (s_axis_tready) begin
			v_s1 <= s_axis_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_fire) begin
			x_s1 <= s_axis_tdata;
		end
	end

	biq_mul u_mul_b0 (.a(coef_b0_q), .b(x_s1),       .p(p_b0));
	biq_mul u_mul_b1 (.a(coef_b1_q), .b(x_hist_1_q), .p(p_b1));
	biq_mul u_mul_b2 (.a(coef_b2_q), .b(x_hist_2_q), .p(p_b2));
	biq_mul u_mul_a1 (.a(coef_a1_q), .b(y_hist_1_q), .p(p_a1));
	biq_mul u_mul_a2 (.a(coef_a2_q), .b(y_hist_2_q), .p(p_a2));

	assign y_s1 = sample_t'(p_b0 + p_b1 + p_b2 - p_a1 - p_a2);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			x_hist_1_q <= COEF_ZERO;
			x_hist_2_q <= COEF_ZERO;
			y_hist_1_q <= COEF_ZERO;
			y_hist_2_q <= COEF_ZERO;
		end else if (adv_s1) begin
			x_hist_2_q <= x_hist_1_q;
			x_hist_1_q <= x_s1;
			y_hist_2_q <= y_hist_1_q;
			y_hist_1_q <= y_s1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (adv_s1) begin
			out_valid_q <= 1'b1;
		end else if (m_axis_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s1) begin
			out_data_q <= y_s1;
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = out_data_q;

	a_adv_fills_out: assert property (@(posedge clk) disable iff (!arst_n)
		adv_s1 |=> m_axis_tvalid)
		else $error("result register not loaded after stage advance");

	a_y_hist_matches_out: assert property (@(posedge clk) disable iff (!arst_n)
		adv_s1 |=> (y_hist_1_q == m_axis_tdata))
		else $error("output history differs from delivered result");

	a_x_hist_shift: assert property (@(posedge clk) disable iff (!arst_n)
		adv_s1 |=> (x_hist_2_q == $past(x_hist_1_q)))
		else $error("input history did not shift");

	a_hist_hold: assert property (@(posedge clk) disable iff (!arst_n)
		!adv_s1 |=> $stable(y_hist_1_q) && $stable(x_hist_1_q))
		else $error("history changed without a sample");

	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		!s_axis_tready |-> (v_s1 && out_valid_q && !m_axis_tready))
		else $error("input stalled with room downstream");

endmodule

`default_nettype wire
